// File: hw/rtl/wfbu_pkg.sv
package wfbu_pkg;

    // Depth of the per-cell PML memory. It is a power of two, so the cell
    // index is reduced to the memory depth by keeping its low bits.
    localparam int MAX_CELLS = 4096;
    localparam int CELL_AW   = $clog2(MAX_CELLS);

    localparam int IDX_W   = 12;
    localparam int Q_W     = 32;
    localparam int FRAC_W  = 16;
    localparam int SUM_W   = 48;
    localparam int H_W     = 31;
    localparam int DECAY_W = 17;
    localparam int KIND_W  = 3;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;

    // Shared multiplier: 34 x 34 signed covers every operand pair.
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DIFF_W  = Q_W + 1;
    localparam int ETERM_W = SUM_W + 1;

    typedef logic signed [Q_W-1:0]     t_q;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [MUL_W-1:0]   t_mul;
    typedef logic signed [PROD_W-1:0]  t_wide;
    typedef logic        [SUM_W-1:0]   t_sum;
    typedef logic        [ETERM_W-1:0] t_eterm;

    localparam t_q   Q_MAX   = {1'b0, {(Q_W-1){1'b1}}};
    localparam t_q   Q_MIN   = {1'b1, {(Q_W-1){1'b0}}};
    localparam t_sum SUM_MAX = '1;
    localparam logic [DECAY_W-1:0] DECAY_ONE = DECAY_W'(1 << FRAC_W);
    localparam logic [H_W-1:0]     SPACING_ONE = H_W'(1 << FRAC_W);

    typedef enum logic [KIND_W-1:0] {
        KIND_DIRICHLET = 3'd0,
        KIND_NEUMANN   = 3'd1,
        KIND_ROBIN     = 3'd2,
        KIND_PERIODIC  = 3'd3,
        KIND_IMPEDANCE = 3'd4,
        KIND_PML       = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        REG_KIND    = 3'd0,
        REG_UPPER   = 3'd1,
        REG_SPLIT   = 3'd2,
        REG_VALUE   = 3'd3,
        REG_SPACING = 3'd4,
        REG_INVSP   = 3'd5,
        REG_DECAY   = 3'd6
    } t_reg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_OP1,
        S_OP2,
        S_OP3,
        S_OP4,
        S_OP5,
        S_OP6,
        S_DONE
    } t_state;

    // Arithmetic shift gives the floor of the division by 2^16.
    function automatic t_wide floor16(input t_wide v);
        return v >>> FRAC_W;
    endfunction

    function automatic t_q sat32(input t_wide v);
        t_q res;
        if (v > t_wide'(Q_MAX)) begin
            res = Q_MAX;
        end else if (v < t_wide'(Q_MIN)) begin
            res = Q_MIN;
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

    // Magnitude of a value that is known to stay below 2^48 in size.
    function automatic t_eterm mag_term(input t_wide v);
        t_wide nv;
        nv = -v;
        return v[PROD_W-1] ? nv[ETERM_W-1:0] : v[ETERM_W-1:0];
    endfunction

    function automatic t_sum sat_add(input t_sum a, input t_eterm b);
        logic [ETERM_W:0] s;
        s = (ETERM_W+1)'(a) + (ETERM_W+1)'(b);
        return (s > (ETERM_W+1)'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// File: hw/rtl/wave_field_boundary_update_top.sv
// Channel  | Direction | Handshake                 | Word
// ---------+-----------+---------------------------+-------------------------------------
// input    | in        | i_in_valid / o_in_stall   | start, boundary flag, index, 4 values
// output   | out       | o_out_valid / i_out_stall | corrected next, two energy totals
// config   | in/out    | psel/penable/pwrite/pready| one register per write
//
// An input word occupies the block from acceptance to the next acceptance for a time
// that depends on its kind: shortest for interior and pass-through cells, longest
// for split-memory PML. The schedule is set by the single shared 34x34 multiplier,
// used once per cycle, and by the read-modify-write of the PML memory. After reset
// the PML memory is cleared one entry per cycle; no input word is taken during that
// pass. A finished word waits in the output register; the next input word is taken
// while it waits, and only the final step holds when the output is still stalled.

module wave_field_boundary_update_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wfbu_pkg::CFG_AW-1:0]         paddr,
    input  logic [wfbu_pkg::CFG_DW-1:0]         pwdata,
    output logic [wfbu_pkg::CFG_DW-1:0]         prdata,
    output logic                                pready,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_start_pass,
    input  logic                                i_on_boundary,
    input  logic [wfbu_pkg::IDX_W-1:0]          i_cell_index,
    input  logic signed [wfbu_pkg::Q_W-1:0]     i_current_value,
    input  logic signed [wfbu_pkg::Q_W-1:0]     i_previous_value,
    input  logic signed [wfbu_pkg::Q_W-1:0]     i_tentative_next,
    input  logic signed [wfbu_pkg::Q_W-1:0]     i_interior_value,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [wfbu_pkg::Q_W-1:0]     o_corrected_next,
    output logic [wfbu_pkg::SUM_W-1:0]          o_reflected_total,
    output logic [wfbu_pkg::SUM_W-1:0]          o_absorbed_total
);

    import wfbu_pkg::*;

    // Configuration registers.
    logic [KIND_W-1:0]  r_kind;
    logic               r_upper;
    logic               r_split;
    t_q                 r_pval;
    logic [H_W-1:0]     r_h;
    logic [H_W-1:0]     r_invh;
    logic [DECAY_W-1:0] r_decay;

    // Sequencer and clearing pass.
    t_state             r_state;
    t_state             n_state;
    logic [CELL_AW-1:0] r_clr_addr;

    // Word under work.
    logic               r_onb;
    logic [CELL_AW-1:0] r_addr;
    t_q                 r_c;
    t_q                 r_n;
    t_q                 r_i;
    t_diff              r_cmq;
    t_diff              r_imc;

    // Datapath registers.
    t_wide              r_prod;
    t_wide              r_acc;
    t_wide              n_acc;
    t_diff              r_tmp;
    t_diff              n_tmp;
    t_q                 r_next;
    t_q                 n_next;
    t_eterm             r_eterm;
    t_eterm             n_eterm;
    t_mul               mul_a;
    t_mul               mul_b;

    // Energy totals.
    t_sum               r_refl;
    t_sum               r_abs;
    t_sum               refl_sum;
    t_sum               abs_sum;
    logic               refl_kind;
    logic               abs_kind;

    // PML memory.
    t_q                 split_mem [MAX_CELLS];
    t_q                 r_mem_q;
    logic               mem_we;
    logic [CELL_AW-1:0] mem_waddr;
    t_q                 mem_wdata;
    logic               upd_we;
    t_q                 upd_wdata;

    logic               cfg_we;
    logic               in_acc;
    logic               out_load;
    logic [DECAY_W-1:0] w_om;
    logic               w_active;

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_DONE) && (!o_out_valid || !i_out_stall);
    assign w_om     = DECAY_ONE - r_decay;

    // ------------------------------------------------------------------
    // Configuration port. The decay factor is clamped to one when written.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_W'(KIND_DIRICHLET);
            r_upper <= 1'b0;
            r_split <= 1'b0;
            r_pval  <= '0;
            r_h     <= SPACING_ONE;
            r_invh  <= SPACING_ONE;
            r_decay <= DECAY_ONE;
        end else if (cfg_we) begin
            case (paddr[CFG_AW-1:2])
                REG_KIND:    r_kind  <= pwdata[KIND_W-1:0];
                REG_UPPER:   r_upper <= pwdata[0];
                REG_SPLIT:   r_split <= pwdata[0];
                REG_VALUE:   r_pval  <= pwdata;
                REG_SPACING: r_h     <= pwdata[H_W-1:0];
                REG_INVSP:   r_invh  <= pwdata[H_W-1:0];
                REG_DECAY: begin
                    r_decay <= (pwdata[DECAY_W-1:0] > DECAY_ONE) ? DECAY_ONE
                                                                 : pwdata[DECAY_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[CFG_AW-1:2])
            REG_KIND:    prdata = CFG_DW'(r_kind);
            REG_UPPER:   prdata = CFG_DW'(r_upper);
            REG_SPLIT:   prdata = CFG_DW'(r_split);
            REG_VALUE:   prdata = r_pval;
            REG_SPACING: prdata = CFG_DW'(r_h);
            REG_INVSP:   prdata = CFG_DW'(r_invh);
            REG_DECAY:   prdata = CFG_DW'(r_decay);
            default:     prdata = '0;
        endcase
    end

    // A boundary cell of a kind that changes the value needs the multiplier.
    always_comb begin
        case (r_kind)
            KIND_DIRICHLET, KIND_NEUMANN, KIND_ROBIN,
            KIND_IMPEDANCE, KIND_PML: w_active = r_onb;
            default:                  w_active = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Next-state logic. Each kind walks a fixed schedule of multiplier steps.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == CELL_AW'(MAX_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_OP1;
                end
            end
            S_OP1: n_state = w_active ? S_OP2 : S_DONE;
            S_OP2: begin
                case (r_kind)
                    KIND_NEUMANN, KIND_ROBIN, KIND_PML: n_state = S_OP3;
                    default:                            n_state = S_DONE;
                endcase
            end
            S_OP3: begin
                case (r_kind)
                    KIND_NEUMANN, KIND_ROBIN: n_state = S_OP4;
                    KIND_PML:                 n_state = r_split ? S_OP4 : S_DONE;
                    default:                  n_state = S_DONE;
                endcase
            end
            S_OP4: begin
                case (r_kind)
                    KIND_NEUMANN, KIND_PML: n_state = S_OP5;
                    default:                n_state = S_DONE;
                endcase
            end
            S_OP5: n_state = (r_kind == KIND_PML) ? S_OP6 : S_DONE;
            S_OP6: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control: multiplier operands and the values stored by each
    // step. The product of one step is read back in the following step.
    // ------------------------------------------------------------------
    always_comb begin
        t_wide w_t;
        t_q    w_m;

        w_t       = floor16(r_prod);
        w_m       = sat32(floor16(r_acc + r_prod));
        mul_a     = '0;
        mul_b     = '0;
        n_acc     = r_acc;
        n_tmp     = r_tmp;
        n_next    = r_next;
        n_eterm   = r_eterm;
        upd_we    = 1'b0;
        upd_wdata = w_m;

        case (r_state)
            S_OP1: begin
                n_next  = r_n;
                n_eterm = '0;
                if (r_onb) begin
                    case (r_kind)
                        KIND_DIRICHLET: begin
                            n_next = r_pval;
                            mul_a  = t_mul'(r_c);
                            mul_b  = t_mul'(r_c);
                        end
                        KIND_NEUMANN: begin
                            mul_a = t_mul'(r_pval);
                            mul_b = t_mul'(r_h);
                        end
                        KIND_ROBIN: begin
                            mul_a = t_mul'(r_imc);
                            mul_b = t_mul'(r_invh);
                        end
                        KIND_IMPEDANCE: begin
                            mul_a = t_mul'(r_pval);
                            mul_b = t_mul'(r_cmq);
                        end
                        KIND_PML: begin
                            mul_a = t_mul'(r_decay);
                            mul_b = r_split ? t_mul'(r_mem_q) : t_mul'(r_n);
                        end
                        default: ;
                    endcase
                end
            end
            S_OP2: begin
                case (r_kind)
                    KIND_DIRICHLET: n_eterm = r_prod[ETERM_W+FRAC_W-1:FRAC_W];
                    KIND_NEUMANN: begin
                        n_next = sat32(r_upper ? t_wide'(r_i) + w_t : t_wide'(r_i) - w_t);
                    end
                    KIND_ROBIN: n_tmp = t_diff'(sat32(w_t));
                    KIND_IMPEDANCE: begin
                        n_next  = sat32(t_wide'(r_c) - w_t);
                        n_eterm = mag_term(w_t);
                    end
                    KIND_PML: begin
                        if (r_split) begin
                            n_acc = r_prod;
                            mul_a = t_mul'(w_om);
                            mul_b = t_mul'(r_cmq);
                        end else begin
                            n_next = sat32(w_t);
                        end
                    end
                    default: ;
                endcase
            end
            S_OP3: begin
                case (r_kind)
                    KIND_NEUMANN: n_tmp = t_diff'(r_next) - t_diff'(r_i);
                    KIND_ROBIN: begin
                        n_next = sat32(t_wide'(r_pval) - t_wide'(r_tmp));
                        mul_a  = t_mul'(r_tmp);
                        mul_b  = t_mul'(r_tmp);
                    end
                    KIND_PML: begin
                        if (r_split) begin
                            // New memory term is written back and kept for the field.
                            n_tmp  = t_diff'(w_m);
                            upd_we = 1'b1;
                            mul_a  = t_mul'(r_decay);
                            mul_b  = t_mul'(r_n);
                        end else begin
                            n_eterm = mag_term(t_wide'(r_c) - t_wide'(r_next));
                        end
                    end
                    default: ;
                endcase
            end
            S_OP4: begin
                case (r_kind)
                    KIND_NEUMANN: begin
                        mul_a = t_mul'(r_tmp);
                        mul_b = t_mul'(r_tmp);
                    end
                    KIND_ROBIN: n_eterm = r_prod[ETERM_W+FRAC_W-1:FRAC_W];
                    KIND_PML: begin
                        n_acc = r_prod;
                        mul_a = t_mul'(w_om);
                        mul_b = t_mul'(r_tmp);
                    end
                    default: ;
                endcase
            end
            S_OP5: begin
                if (r_kind == KIND_PML) begin
                    n_next = sat32(floor16(r_acc - r_prod));
                end else begin
                    n_eterm = r_prod[ETERM_W+FRAC_W-1:FRAC_W];
                end
            end
            S_OP6: n_eterm = mag_term(t_wide'(r_c) - t_wide'(r_next));
            default: ;
        endcase
    end

    always_comb begin
        case (r_kind)
            KIND_DIRICHLET, KIND_NEUMANN, KIND_ROBIN: begin
                refl_kind = r_onb;
                abs_kind  = 1'b0;
            end
            KIND_IMPEDANCE, KIND_PML: begin
                refl_kind = 1'b0;
                abs_kind  = r_onb;
            end
            default: begin
                refl_kind = 1'b0;
                abs_kind  = 1'b0;
            end
        endcase
    end

    assign refl_sum = refl_kind ? sat_add(r_refl, r_eterm) : r_refl;
    assign abs_sum  = abs_kind  ? sat_add(r_abs, r_eterm)  : r_abs;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_refl     <= '0;
            r_abs      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + CELL_AW'(1);
            end
            if (in_acc && i_start_pass) begin
                r_refl <= '0;
                r_abs  <= '0;
            end else if (out_load) begin
                r_refl <= refl_sum;
                r_abs  <= abs_sum;
            end
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_onb  <= i_on_boundary;
            r_addr <= i_cell_index[CELL_AW-1:0];
            r_c    <= i_current_value;
            r_n    <= i_tentative_next;
            r_i    <= i_interior_value;
            r_cmq  <= t_diff'(i_current_value) - t_diff'(i_previous_value);
            r_imc  <= t_diff'(i_interior_value) - t_diff'(i_current_value);
        end
        r_prod  <= mul_a * mul_b;
        r_acc   <= n_acc;
        r_tmp   <= n_tmp;
        r_next  <= n_next;
        r_eterm <= n_eterm;
        if (out_load) begin
            o_corrected_next  <= r_next;
            o_reflected_total <= refl_sum;
            o_absorbed_total  <= abs_sum;
        end
    end

    // ------------------------------------------------------------------
    // PML memory: cleared after reset, then read at acceptance and written
    // once per split-memory cell.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = upd_we;
            mem_waddr = r_addr;
            mem_wdata = upd_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            split_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem_q <= split_mem[i_cell_index[CELL_AW-1:0]];
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while a word is still in work");

    a_clear_writes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (mem_we && mem_wdata == '0))
        else $error("clearing pass wrote a nonzero entry");

    a_mem_write_split_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != S_CLEAR) |->
            (r_kind == KIND_PML && r_split && r_onb && r_state == S_OP3))
        else $error("PML memory written outside a split-memory cell");

    a_refl_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && i_start_pass) |=> (r_refl >= $past(r_refl)))
        else $error("reflected total fell without a new pass");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("output word raised outside the final step");
`endif

endmodule
